### design/rrc_pkg.sv
// ----------------------------------------------------------------------------
// Row-range cache package
// Field widths, entry word layout, command codes and the types shared by the
// sequencer and the scan unit.
// ----------------------------------------------------------------------------
package rrc_pkg;

    localparam int CAPACITY_DEFAULT = 16;

    // Item field widths.
    localparam int CMD_W   = 2;
    localparam int START_W = 31;
    localparam int COUNT_W = 16;
    localparam int STAMP_W = 48;
    localparam int USES_W  = 16;
    localparam int MAXE_W  = 5;
    localparam int OSLOT_W = 4;

    // Stream packing.
    localparam int IN_START_LSB = 0;
    localparam int IN_COUNT_LSB = IN_START_LSB + START_W;
    localparam int IN_NOW_LSB   = IN_COUNT_LSB + COUNT_W;
    localparam int IN_DATA_W    = ((IN_NOW_LSB + STAMP_W + 7) / 8) * 8;
    localparam int OUT_DATA_W   = OSLOT_W + COUNT_W + OSLOT_W;
    localparam int OUT_USER_W   = 4;

    // Entry word layout, the rank sits on top with a width set by the capacity.
    localparam int START_LSB = 0;
    localparam int LEN_LSB   = START_LSB + START_W;
    localparam int STAMP_LSB = LEN_LSB + COUNT_W;
    localparam int USES_LSB  = STAMP_LSB + STAMP_W;
    localparam int RANK_LSB  = USES_LSB + USES_W;

    // Eviction score is stamp minus uses times the weight.
    localparam int SCORE_WEIGHT = 1000;
    localparam int WEIGHT_W     = 10;
    localparam int PROD_W       = USES_W + WEIGHT_W;
    localparam int SCORE_W      = STAMP_W + 2;

    localparam logic [USES_W-1:0] USES_MAX          = {USES_W{1'b1}};
    localparam logic [MAXE_W-1:0] MAX_ENTRIES_RESET = 5'd16;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_CLEAR  = 2'd2
    } t_cmd;

    typedef enum logic {
        MODE_MATCH,
        MODE_EVICT
    } t_scan_mode;

    typedef struct packed {
        logic exact_found;
        logic best_found;
        logic free_found;
    } t_scan_flags;

endpackage

### design/rrc_entry_mem.sv
// ----------------------------------------------------------------------------
// Row-range cache entry memory
// One write port and one read port with registered read data, one entry word
// per slot.
// ----------------------------------------------------------------------------
module rrc_entry_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/rrc_scan_unit.sv
// ----------------------------------------------------------------------------
// Row-range cache scan unit
// Evaluates one entry word per cycle (match, cover and eviction score) in a
// registered stage and keeps the best, exact and first free slots of the pass.
// ----------------------------------------------------------------------------
module rrc_scan_unit #(
    parameter int CAPACITY = rrc_pkg::CAPACITY_DEFAULT,
    localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int RANK_W = SLOT_W,
    localparam int WORD_W = rrc_pkg::RANK_LSB + RANK_W
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_clear,
    input  rrc_pkg::t_scan_mode          i_mode,
    input  logic                         i_vld,
    input  logic [SLOT_W-1:0]            i_slot,
    input  logic                         i_ent_valid,
    input  logic [WORD_W-1:0]            i_word,
    input  logic [rrc_pkg::START_W-1:0]  i_start,
    input  logic [rrc_pkg::COUNT_W-1:0]  i_count,
    output logic                         o_busy,
    output rrc_pkg::t_scan_flags         o_flags,
    output logic [SLOT_W-1:0]            o_exact_slot,
    output logic [SLOT_W-1:0]            o_best_slot,
    output logic [SLOT_W-1:0]            o_free_slot,
    output logic [RANK_W-1:0]            o_best_rank,
    output logic [rrc_pkg::COUNT_W-1:0]  o_best_offset
);

    import rrc_pkg::*;

    logic [START_W-1:0]        e_start;
    logic [COUNT_W-1:0]        e_len;
    logic [STAMP_W-1:0]        e_stamp;
    logic [USES_W-1:0]         e_uses;
    logic [RANK_W-1:0]         e_rank;
    logic [START_W:0]          e_end;
    logic [START_W:0]          q_end;
    logic [PROD_W-1:0]         e_prod;
    logic signed [SCORE_W-1:0] e_score;
    logic [START_W-1:0]        e_diff;

    logic                      r_s1_vld;
    logic                      r_s1_ok;
    logic                      r_s1_exact;
    logic                      r_s1_cover;
    logic signed [SCORE_W-1:0] r_s1_score;
    logic [RANK_W-1:0]         r_s1_rank;
    logic [SLOT_W-1:0]         r_s1_slot;
    logic [COUNT_W-1:0]        r_s1_off;

    logic                      r_exact_found;
    logic                      r_best_found;
    logic                      r_free_found;
    logic [SLOT_W-1:0]         r_exact_slot;
    logic [SLOT_W-1:0]         r_best_slot;
    logic [SLOT_W-1:0]         r_free_slot;
    logic [RANK_W-1:0]         r_best_rank;
    logic signed [SCORE_W-1:0] r_best_score;
    logic [COUNT_W-1:0]        r_best_off;

    logic                      take;

    assign e_start = i_word[START_LSB +: START_W];
    assign e_len   = i_word[LEN_LSB +: COUNT_W];
    assign e_stamp = i_word[STAMP_LSB +: STAMP_W];
    assign e_uses  = i_word[USES_LSB +: USES_W];
    assign e_rank  = i_word[RANK_LSB +: RANK_W];

    assign e_end   = (START_W+1)'(e_start) + (START_W+1)'(e_len);
    assign q_end   = (START_W+1)'(i_start) + (START_W+1)'(i_count);
    assign e_prod  = PROD_W'(e_uses) * PROD_W'(SCORE_WEIGHT);
    assign e_score = SCORE_W'(e_stamp) - SCORE_W'(e_prod);
    assign e_diff  = i_start - e_start;

    // Evaluation stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_vld;
        end
        r_s1_ok    <= i_ent_valid;
        r_s1_exact <= i_ent_valid && (e_start == i_start) && (e_len == i_count);
        r_s1_cover <= i_ent_valid && (e_start <= i_start) && (e_end >= q_end);
        r_s1_score <= e_score;
        r_s1_rank  <= e_rank;
        r_s1_slot  <= i_slot;
        r_s1_off   <= e_diff[COUNT_W-1:0];
    end

    // The lowest rank wins among covering entries; for eviction the lowest
    // score wins and equal scores fall back to the lowest rank.
    always_comb begin
        unique case (i_mode)
            MODE_EVICT: begin
                take = r_s1_ok && (!r_best_found || (r_s1_score < r_best_score) ||
                       ((r_s1_score == r_best_score) && (r_s1_rank < r_best_rank)));
            end
            MODE_MATCH: begin
                take = r_s1_cover && (!r_best_found || (r_s1_rank < r_best_rank));
            end
            default: begin
                take = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exact_found <= 1'b0;
            r_best_found  <= 1'b0;
            r_free_found  <= 1'b0;
        end else if (i_clear) begin
            r_exact_found <= 1'b0;
            r_best_found  <= 1'b0;
            r_free_found  <= 1'b0;
        end else if (r_s1_vld) begin
            if (take) begin
                r_best_found <= 1'b1;
                r_best_slot  <= r_s1_slot;
                r_best_rank  <= r_s1_rank;
                r_best_score <= r_s1_score;
                r_best_off   <= r_s1_off;
            end
            if ((i_mode == MODE_MATCH) && r_s1_exact) begin
                r_exact_found <= 1'b1;
                r_exact_slot  <= r_s1_slot;
            end
            // Slots arrive in ascending order, so the first empty one is kept.
            if (!r_s1_ok && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_slot  <= r_s1_slot;
            end
        end
    end

    assign o_busy              = r_s1_vld;
    assign o_flags.exact_found = r_exact_found;
    assign o_flags.best_found  = r_best_found;
    assign o_flags.free_found  = r_free_found;
    assign o_exact_slot        = r_exact_slot;
    assign o_best_slot         = r_best_slot;
    assign o_free_slot         = r_free_slot;
    assign o_best_rank         = r_best_rank;
    assign o_best_offset       = r_best_off;

endmodule

### design/row_range_cache_with_scored_eviction_unit.sv
// ----------------------------------------------------------------------------
// Row-range cache with scored eviction
// Tag and replacement engine for a cache of row ranges. Each input beat carries
// a lookup, an insert or a clear; each produces exactly one result beat. The
// entries live in a single-port-write memory that one scan unit walks a slot a
// cycle. A lookup hit or an insert that needs no eviction goes through the scan,
// fetch, update and result states; a lookup miss goes from the scan straight to
// the result state. An insert that must evict makes two passes. A clear, an
// empty insert or an unused command goes from acceptance straight to the result
// state. The block takes one beat at a time and is ready again the cycle
// after its result is loaded; a finished result waits in the output register
// while the next beat is accepted, and a second finished result holds the block
// until the first one is taken. The max_entries register resets to 16 and is
// written only while the block is idle; a write offered in the same cycle as an
// input beat goes first.
// ----------------------------------------------------------------------------
module row_range_cache_with_scored_eviction_unit #(
    parameter int CAPACITY = rrc_pkg::CAPACITY_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // start_row, row_count, now_ms, zero pad
    input  logic [rrc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // cmd
    input  logic [rrc_pkg::CMD_W-1:0]       s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // slot, row_offset, evicted_slot
    output logic [rrc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // hit, exact_match, evicted, stored
    output logic [rrc_pkg::OUT_USER_W-1:0]  m_axis_tuser,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rrc_pkg::MAXE_W-1:0]      i_cfg_data
);

    import rrc_pkg::*;

    localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int RANK_W = SLOT_W;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > MAXE_W) ? CNT_W : MAXE_W;
    localparam int WORD_W = RANK_LSB + RANK_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FETCH,
        ST_UPDATE,
        ST_RESULT
    } t_state;

    typedef enum logic [1:0] {
        UPD_TOUCH,
        UPD_RESET,
        UPD_APPEND
    } t_upd;

    t_state             r_state;
    t_cmd               r_cmd;
    t_scan_mode         r_mode;
    t_upd               r_upd;
    logic [START_W-1:0] r_start;
    logic [COUNT_W-1:0] r_count;
    logic [STAMP_W-1:0] r_now;
    logic [MAXE_W-1:0]  r_max;
    logic [CAPACITY-1:0] r_valid;
    logic [CNT_W-1:0]   r_used;
    logic [SLOT_W-1:0]  r_addr;
    logic               r_issue;
    logic               r_p1_vld;
    logic [SLOT_W-1:0]  r_p1_slot;
    logic [SLOT_W-1:0]  r_tgt;
    logic               r_hit;
    logic               r_exact;
    logic [COUNT_W-1:0] r_off;
    logic               r_ev;
    logic [SLOT_W-1:0]  r_ev_slot;
    logic [RANK_W-1:0]  r_ev_rank;
    logic               r_stored;

    logic               r_ovld;
    logic               r_o_hit;
    logic               r_o_exact;
    logic [OSLOT_W-1:0] r_o_slot;
    logic [COUNT_W-1:0] r_o_off;
    logic               r_o_ev;
    logic [OSLOT_W-1:0] r_o_evslot;
    logic               r_o_stored;

    t_cmd               in_cmd;
    logic [START_W-1:0] in_start;
    logic [COUNT_W-1:0] in_count;
    logic [STAMP_W-1:0] in_now;
    logic               accept;
    logic               evict_need;
    logic               scan_done;
    logic               scan_clear;

    logic               mem_we;
    logic [SLOT_W-1:0]  mem_waddr;
    logic [WORD_W-1:0]  mem_wdata;
    logic               mem_re;
    logic [SLOT_W-1:0]  mem_raddr;
    logic [WORD_W-1:0]  mem_rdata;
    logic [RANK_W-1:0]  rd_rank;
    logic [USES_W-1:0]  rd_uses;

    logic               scan_busy;
    t_scan_flags        scan_flags;
    logic [SLOT_W-1:0]  exact_slot;
    logic [SLOT_W-1:0]  best_slot;
    logic [SLOT_W-1:0]  free_slot;
    logic [RANK_W-1:0]  best_rank;
    logic [COUNT_W-1:0] best_offset;

    assign in_cmd   = t_cmd'(s_axis_tuser);
    assign in_start = s_axis_tdata[IN_START_LSB +: START_W];
    assign in_count = s_axis_tdata[IN_COUNT_LSB +: COUNT_W];
    assign in_now   = s_axis_tdata[IN_NOW_LSB +: STAMP_W];

    // A configuration write takes the idle cycle before a beat offered alongside it.
    assign s_axis_tready = (r_state == ST_IDLE) && !i_cfg_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = (r_state == ST_IDLE);

    // The table evicts at the programmed limit, and always once it is full.
    assign evict_need = (r_used != '0) &&
                        ((CMP_W'(r_used) >= CMP_W'(r_max)) || (r_used == CNT_W'(CAPACITY)));

    assign scan_done  = (r_state == ST_SCAN) && !r_issue && !r_p1_vld && !scan_busy;
    assign scan_clear = ((r_state == ST_IDLE) && accept) ||
                        (scan_done && (r_mode == MODE_EVICT));

    assign rd_rank = mem_rdata[RANK_LSB +: RANK_W];
    assign rd_uses = mem_rdata[USES_LSB +: USES_W];

    assign mem_re    = ((r_state == ST_SCAN) && r_issue) || (r_state == ST_FETCH);
    assign mem_raddr = (r_state == ST_FETCH) ? r_tgt : r_addr;

    // Write port: rank close-up during the pass after an eviction, and the
    // final entry update.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_p1_slot;
        mem_wdata = mem_rdata;
        if ((r_state == ST_SCAN) && r_ev && r_p1_vld && r_valid[r_p1_slot] &&
            (rd_rank > r_ev_rank)) begin
            mem_we                           = 1'b1;
            mem_wdata[RANK_LSB +: RANK_W]    = rd_rank - RANK_W'(1);
        end else if (r_state == ST_UPDATE) begin
            mem_we    = 1'b1;
            mem_waddr = r_tgt;
            unique case (r_upd)
                UPD_TOUCH: begin
                    mem_wdata[STAMP_LSB +: STAMP_W] = r_now;
                    mem_wdata[USES_LSB +: USES_W]   = (rd_uses == USES_MAX) ?
                                                      rd_uses : rd_uses + USES_W'(1);
                end
                UPD_RESET: begin
                    mem_wdata[STAMP_LSB +: STAMP_W] = r_now;
                    mem_wdata[USES_LSB +: USES_W]   = '0;
                end
                UPD_APPEND: begin
                    mem_wdata = {RANK_W'(r_used), USES_W'(0), r_now, r_count, r_start};
                end
                default: begin
                    mem_we = 1'b0;
                end
            endcase
        end
    end

    rrc_entry_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (WORD_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    rrc_scan_unit #(
        .CAPACITY (CAPACITY)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_clear       (scan_clear),
        .i_mode        (r_mode),
        .i_vld         (r_p1_vld),
        .i_slot        (r_p1_slot),
        .i_ent_valid   (r_valid[r_p1_slot]),
        .i_word        (mem_rdata),
        .i_start       (r_start),
        .i_count       (r_count),
        .o_busy        (scan_busy),
        .o_flags       (scan_flags),
        .o_exact_slot  (exact_slot),
        .o_best_slot   (best_slot),
        .o_free_slot   (free_slot),
        .o_best_rank   (best_rank),
        .o_best_offset (best_offset)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_valid  <= '0;
            r_used   <= '0;
            r_max    <= MAX_ENTRIES_RESET;
            r_issue  <= 1'b0;
            r_p1_vld <= 1'b0;
            r_ev     <= 1'b0;
            r_ovld   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_max <= i_cfg_data;
            end
            r_p1_vld  <= (r_state == ST_SCAN) && r_issue;
            r_p1_slot <= r_addr;
            // In the result state the output register is either reloaded or held.
            if (m_axis_tready && (r_state != ST_RESULT)) begin
                r_ovld <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_cmd     <= in_cmd;
                        r_start   <= in_start;
                        r_count   <= in_count;
                        r_now     <= in_now;
                        r_hit     <= 1'b0;
                        r_exact   <= 1'b0;
                        r_off     <= '0;
                        r_ev      <= 1'b0;
                        r_ev_slot <= '0;
                        r_ev_rank <= '0;
                        r_stored  <= 1'b0;
                        r_tgt     <= '0;
                        r_addr    <= '0;
                        unique case (in_cmd)
                            CMD_LOOKUP: begin
                                r_mode  <= MODE_MATCH;
                                r_issue <= 1'b1;
                                r_state <= ST_SCAN;
                            end
                            CMD_INSERT: begin
                                if (in_count == '0) begin
                                    r_state <= ST_RESULT;
                                end else begin
                                    r_mode  <= evict_need ? MODE_EVICT : MODE_MATCH;
                                    r_issue <= 1'b1;
                                    r_state <= ST_SCAN;
                                end
                            end
                            CMD_CLEAR: begin
                                r_valid <= '0;
                                r_used  <= '0;
                                r_state <= ST_RESULT;
                            end
                            default: begin
                                r_state <= ST_RESULT;
                            end
                        endcase
                    end
                end

                ST_SCAN: begin
                    if (r_issue) begin
                        if (r_addr == SLOT_W'(CAPACITY - 1)) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_addr <= r_addr + SLOT_W'(1);
                        end
                    end
                    if (scan_done) begin
                        if (r_mode == MODE_EVICT) begin
                            if (scan_flags.best_found) begin
                                r_valid[best_slot] <= 1'b0;
                                r_used             <= r_used - CNT_W'(1);
                                r_ev               <= 1'b1;
                                r_ev_slot          <= best_slot;
                                r_ev_rank          <= best_rank;
                            end
                            // Second pass: exact match, free slot and rank close-up.
                            r_mode  <= MODE_MATCH;
                            r_addr  <= '0;
                            r_issue <= 1'b1;
                        end else if (r_cmd == CMD_LOOKUP) begin
                            if (scan_flags.exact_found) begin
                                r_hit   <= 1'b1;
                                r_exact <= 1'b1;
                                r_tgt   <= exact_slot;
                                r_upd   <= UPD_TOUCH;
                                r_state <= ST_FETCH;
                            end else if (scan_flags.best_found) begin
                                // A covering entry is touched even for zero rows.
                                r_hit   <= (r_count != '0);
                                r_tgt   <= best_slot;
                                r_off   <= best_offset;
                                r_upd   <= UPD_TOUCH;
                                r_state <= ST_FETCH;
                            end else begin
                                r_state <= ST_RESULT;
                            end
                        end else begin
                            if (scan_flags.exact_found) begin
                                r_exact  <= 1'b1;
                                r_stored <= 1'b1;
                                r_tgt    <= exact_slot;
                                r_upd    <= UPD_RESET;
                                r_state  <= ST_FETCH;
                            end else if (scan_flags.free_found) begin
                                r_stored <= 1'b1;
                                r_tgt    <= free_slot;
                                r_upd    <= UPD_APPEND;
                                r_state  <= ST_FETCH;
                            end else begin
                                r_state <= ST_RESULT;
                            end
                        end
                    end
                end

                ST_FETCH: begin
                    r_state <= ST_UPDATE;
                end

                ST_UPDATE: begin
                    if (r_upd == UPD_APPEND) begin
                        r_valid[r_tgt] <= 1'b1;
                        r_used         <= r_used + CNT_W'(1);
                    end
                    r_state <= ST_RESULT;
                end

                ST_RESULT: begin
                    if (!r_ovld || m_axis_tready) begin
                        r_ovld     <= 1'b1;
                        r_o_hit    <= r_hit;
                        r_o_exact  <= r_exact;
                        r_o_slot   <= OSLOT_W'(r_tgt);
                        r_o_off    <= r_off;
                        r_o_ev     <= r_ev;
                        r_o_evslot <= OSLOT_W'(r_ev_slot);
                        r_o_stored <= r_stored;
                        r_state    <= ST_IDLE;
                    end
                end

                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {r_o_evslot, r_o_off, r_o_slot};
    assign m_axis_tuser  = {r_o_stored, r_o_ev, r_o_exact, r_o_hit};

    a_used_tracks_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_used))
        else $error("entry count differs from the number of valid slots");

    a_no_write_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !mem_we)
        else $error("entry memory written while no beat is in progress");

    a_evict_leaves_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ev) |-> (r_used < CNT_W'(CAPACITY)))
        else $error("eviction did not free a slot");

endmodule

### tb/tb_row_range_cache_with_scored_eviction_unit.sv
// ----------------------------------------------------------------------------
// Testbench for the row-range cache with scored eviction
// Drives lookup, insert and clear beats into the tag engine under bursty input
// and a stalling output, and predicts the result beats with a behavioural copy
// of the entry table: exact and covering matches, use counts, scored eviction
// and rank close-up. The entry limit is stepped through several settings,
// including zero, one, the full capacity and a value beyond it.
// ----------------------------------------------------------------------------
module tb_row_range_cache_with_scored_eviction_unit;

    import rrc_pkg::*;

    localparam int CAP          = CAPACITY_DEFAULT;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int TAIL_CYCLES  = 60;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_ITEMS  = 60;
    localparam int KNOWN_DEPTH  = 24;

    // Command code that the block has no use for.
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    typedef struct packed {
        logic               hit;
        logic               exact;
        logic [OSLOT_W-1:0] slot;
        logic [COUNT_W-1:0] offset;
        logic               evicted;
        logic [OSLOT_W-1:0] ev_slot;
        logic               stored;
    } t_range_result;

    localparam t_range_result NO_RESULT    = '0;
    localparam t_range_result FILLED_SLOT0 = '{1'b0, 1'b0, 4'd0, 16'd0, 1'b0, 4'd0, 1'b1};
    localparam t_range_result FILLED_SLOT1 = '{1'b0, 1'b0, 4'd1, 16'd0, 1'b0, 4'd0, 1'b1};

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [START_W-1:0] start;
        logic [COUNT_W-1:0] count;
        logic [STAMP_W-1:0] now;
        logic               typed;
        t_range_result      want;
    } t_range_beat;

    localparam int DIRECTED_ROWS = 19;

    // Rows with typed set carry a result that is plain from the table state;
    // the rest go through the predictor.
    t_range_beat directed_plan [DIRECTED_ROWS] = '{
        '{CMD_LOOKUP, 31'd0,          16'd0,     48'd0,              1'b1, NO_RESULT},
        '{CMD_SPARE,  31'h7FFF_FFFF,  16'hFFFF,  48'hFFFF_FFFF_FFFF, 1'b1, NO_RESULT},
        '{CMD_INSERT, 31'd5,          16'd0,     48'd7,              1'b1, NO_RESULT},
        '{CMD_INSERT, 31'd100,        16'd50,    48'd1000,           1'b1, FILLED_SLOT0},
        '{CMD_INSERT, 31'h7FFF_0000,  16'hFFFF,  48'hFFFF_FFFF_FFFF, 1'b1, FILLED_SLOT1},
        '{CMD_LOOKUP, 31'd100,        16'd50,    48'd2000,           1'b0, NO_RESULT},
        '{CMD_LOOKUP, 31'd110,        16'd10,    48'd2100,           1'b0, NO_RESULT},
        '{CMD_LOOKUP, 31'd120,        16'd0,     48'd2200,           1'b0, NO_RESULT},
        '{CMD_LOOKUP, 31'h7FFF_FFFF,  16'd0,     48'd2300,           1'b0, NO_RESULT},
        '{CMD_LOOKUP, 31'h7FFF_0000,  16'hFFFF,  48'd2400,           1'b0, NO_RESULT},
        '{CMD_LOOKUP, 31'd90,         16'd20,    48'd2500,           1'b0, NO_RESULT},
        '{CMD_INSERT, 31'd100,        16'd50,    48'd2600,           1'b0, NO_RESULT},
        '{CMD_INSERT, 31'd100,        16'd30,    48'd2700,           1'b0, NO_RESULT},
        '{CMD_LOOKUP, 31'd100,        16'd30,    48'd2800,           1'b0, NO_RESULT},
        '{CMD_LOOKUP, 31'd0,          16'd1,     48'd0,              1'b0, NO_RESULT},
        '{CMD_CLEAR,  31'd100,        16'd50,    48'd2900,           1'b1, NO_RESULT},
        '{CMD_LOOKUP, 31'd100,        16'd50,    48'd3000,           1'b1, NO_RESULT},
        '{CMD_INSERT, 31'd0,          16'hFFFF,  48'd0,              1'b1, FILLED_SLOT0},
        '{CMD_LOOKUP, 31'd0,          16'hFFFF,  48'd3100,           1'b0, NO_RESULT}
    };

    int phase_limits [7] = '{1, 0, 31, 3, 16, 7, 2};

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // start_row, row_count, now_ms, zero pad
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    // cmd
    logic [CMD_W-1:0]       s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // slot, row_offset, evicted_slot
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    // hit, exact_match, evicted, stored
    logic [OUT_USER_W-1:0]  m_axis_tuser;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [MAXE_W-1:0]      i_cfg_data = '0;

    // Shadow copy of the entry table.
    logic               tag_valid [CAP];
    logic [START_W-1:0] tag_start [CAP];
    logic [COUNT_W-1:0] tag_len   [CAP];
    logic [STAMP_W-1:0] tag_stamp [CAP];
    logic [USES_W-1:0]  tag_uses  [CAP];
    int                 tag_rank  [CAP];
    int                 scan_order [CAP];
    int                 tag_used;
    logic [MAXE_W-1:0]  tag_limit;

    t_range_result                  pending_results [$];
    logic [START_W+COUNT_W-1:0]     known_ranges [$];
    logic [STAMP_W-1:0]             sim_ms = '0;

    int  cycle_count = 0;
    int  mismatch_count = 0;
    int  beats_sent = 0;
    int  results_seen = 0;
    int  hits_predicted = 0;
    int  evictions_predicted = 0;
    int  limits_walked = 1;
    int  burst_left = 0;
    int  ready_run = 0;
    int  hold_left = 0;
    int  hold_requests = 0;
    int  hold_served = 0;
    bit  tx_gaps = 1'b1;
    bit  rx_stalls = 1'b1;
    t_range_result got_result;
    t_range_result want_result;

    row_range_cache_with_scored_eviction_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     pending_results.size());
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Lists valid slots by rank; ranks of valid entries are always 0..tag_used-1.
    function automatic int fill_order();
        foreach (tag_valid[k]) begin
            if (tag_valid[k]) scan_order[tag_rank[k]] = k;
        end
        return tag_used;
    endfunction

    function automatic void touch_entry(input int s, input logic [STAMP_W-1:0] now);
        tag_stamp[s] = now;
        if (tag_uses[s] != USES_MAX) tag_uses[s] = tag_uses[s] + 1'b1;
    endfunction

    function automatic t_range_result cache_access(input t_range_beat beat);
        t_range_result res;
        int            n;
        int            s;
        int            pick;
        bit            found;
        longint        best;
        longint        score;
        res = '0;
        found = 1'b0;
        pick = 0;
        best = 0;
        case (beat.cmd)
            CMD_LOOKUP: begin
                n = fill_order();
                for (int r = 0; r < n; r++) begin
                    s = scan_order[r];
                    if (!found && tag_start[s] == beat.start && tag_len[s] == beat.count) begin
                        touch_entry(s, beat.now);
                        found = 1'b1;
                        res.hit = 1'b1;
                        res.exact = 1'b1;
                        res.slot = s[OSLOT_W-1:0];
                    end
                end
                for (int r = 0; r < n; r++) begin
                    s = scan_order[r];
                    if (!found && tag_start[s] <= beat.start &&
                            longint'(tag_start[s]) + longint'(tag_len[s]) >=
                            longint'(beat.start) + longint'(beat.count)) begin
                        touch_entry(s, beat.now);
                        found = 1'b1;
                        // A zero-row lookup still refreshes the entry but is no hit.
                        res.hit = (beat.count != '0);
                        res.slot = s[OSLOT_W-1:0];
                        res.offset = COUNT_W'(beat.start - tag_start[s]);
                    end
                end
            end
            CMD_INSERT: begin
                if (beat.count != '0) begin
                    if (tag_used > 0 && (tag_used >= int'(tag_limit) || tag_used >= CAP)) begin
                        n = fill_order();
                        for (int r = 0; r < n; r++) begin
                            s = scan_order[r];
                            score = longint'(tag_stamp[s]) - longint'(tag_uses[s]) * SCORE_WEIGHT;
                            if (r == 0 || score < best) begin
                                best = score;
                                pick = s;
                            end
                        end
                        // Ranks behind the victim close up by one.
                        foreach (tag_valid[k]) begin
                            if (tag_valid[k] && tag_rank[k] > tag_rank[pick])
                                tag_rank[k] = tag_rank[k] - 1;
                        end
                        tag_valid[pick] = 1'b0;
                        tag_used = tag_used - 1;
                        res.evicted = 1'b1;
                        res.ev_slot = pick[OSLOT_W-1:0];
                    end
                    n = fill_order();
                    for (int r = 0; r < n; r++) begin
                        s = scan_order[r];
                        if (!found && tag_start[s] == beat.start && tag_len[s] == beat.count) begin
                            tag_stamp[s] = beat.now;
                            tag_uses[s] = '0;
                            found = 1'b1;
                            res.exact = 1'b1;
                            res.slot = s[OSLOT_W-1:0];
                            res.stored = 1'b1;
                        end
                    end
                    for (int k = 0; k < CAP; k++) begin
                        if (!found && !tag_valid[k]) begin
                            tag_valid[k] = 1'b1;
                            tag_start[k] = beat.start;
                            tag_len[k] = beat.count;
                            tag_stamp[k] = beat.now;
                            tag_uses[k] = '0;
                            tag_rank[k] = tag_used;
                            tag_used = tag_used + 1;
                            found = 1'b1;
                            res.slot = k[OSLOT_W-1:0];
                            res.stored = 1'b1;
                        end
                    end
                end
            end
            CMD_CLEAR: begin
                foreach (tag_valid[k]) tag_valid[k] = 1'b0;
                tag_used = 0;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 100) $display("[cycle %0d] mismatch: %s", cycle_count, what);
    endtask

    task automatic check_field(input string name, input logic [COUNT_W-1:0] got_v,
                               input logic [COUNT_W-1:0] want_v);
        if (got_v !== want_v)
            flag_mismatch($sformatf("result %0d %s is %0h, expected %0h", results_seen, name,
                                    got_v, want_v));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            got_result.slot    = m_axis_tdata[OSLOT_W-1:0];
            got_result.offset  = m_axis_tdata[OSLOT_W +: COUNT_W];
            got_result.ev_slot = m_axis_tdata[OSLOT_W+COUNT_W +: OSLOT_W];
            got_result.hit     = m_axis_tuser[0];
            got_result.exact   = m_axis_tuser[1];
            got_result.evicted = m_axis_tuser[2];
            got_result.stored  = m_axis_tuser[3];
            if (pending_results.size() == 0) begin
                flag_mismatch($sformatf("result beat %0d arrived with nothing expected",
                                        results_seen));
            end else begin
                want_result = pending_results.pop_front();
                check_field("hit", COUNT_W'(got_result.hit), COUNT_W'(want_result.hit));
                check_field("exact_match", COUNT_W'(got_result.exact),
                            COUNT_W'(want_result.exact));
                check_field("slot", COUNT_W'(got_result.slot), COUNT_W'(want_result.slot));
                check_field("row_offset", got_result.offset, want_result.offset);
                check_field("evicted", COUNT_W'(got_result.evicted),
                            COUNT_W'(want_result.evicted));
                check_field("evicted_slot", COUNT_W'(got_result.ev_slot),
                            COUNT_W'(want_result.ev_slot));
                check_field("stored", COUNT_W'(got_result.stored), COUNT_W'(want_result.stored));
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------------
    // Result side: random stall runs, plus one long hold-off on request.
    // ------------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (!rx_stalls) begin
            m_axis_tready <= 1'b1;
        end else if (ready_run > 0) begin
            ready_run <= ready_run - 1;
        end else begin
            m_axis_tready <= !m_axis_tready;
            ready_run <= m_axis_tready ? int'($urandom_range(0, 5)) : int'($urandom_range(0, 9));
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    task automatic offer_item(input t_range_beat beat);
        t_range_result predicted;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= beat.cmd;
        s_axis_tdata <= {1'b0, beat.now, beat.count, beat.start};
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = cache_access(beat);
        pending_results.push_back(beat.typed ? beat.want : predicted);
        beats_sent++;
        if (predicted.hit) hits_predicted++;
        if (predicted.evicted) evictions_predicted++;
    endtask

    task automatic sender_pause();
        if (tx_gaps) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(0, 12);
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
        end
    endtask

    // Most beats reuse a small pool of ranges so that lookups hit and inserts
    // collide; a few carry full-width noise.
    task automatic draw_item(output t_range_beat beat);
        int roll;
        int mode;
        int ofs;
        logic [START_W+COUNT_W-1:0] known;
        roll = $urandom_range(0, 99);
        mode = $urandom_range(0, 19);
        beat = '0;
        if (roll < 2) beat.cmd = CMD_CLEAR;
        else if (roll < 4) beat.cmd = CMD_SPARE;
        else if (roll < 48) beat.cmd = CMD_INSERT;
        else beat.cmd = CMD_LOOKUP;
        // Time creeps forward in small steps, so scores tie and use counts weigh in.
        sim_ms = sim_ms + STAMP_W'($urandom_range(0, 3));
        if ($urandom_range(0, 19) == 0) beat.now = STAMP_W'({$urandom, $urandom});
        else beat.now = sim_ms;
        if (mode == 0) begin
            beat.start = START_W'($urandom);
            beat.count = COUNT_W'($urandom);
        end else if (mode < 12 && known_ranges.size() > 0) begin
            known = known_ranges[$urandom_range(0, known_ranges.size() - 1)];
            beat.start = known[START_W-1:0];
            beat.count = known[START_W +: COUNT_W];
            if (beat.cmd == CMD_LOOKUP && mode > 4) begin
                // A range inside a known one, sometimes of zero rows.
                ofs = $urandom_range(0, int'(beat.count) - 1);
                beat.start = beat.start + START_W'(ofs);
                beat.count = COUNT_W'($urandom_range(0, int'(beat.count) - ofs));
            end
        end else begin
            beat.start = START_W'($urandom_range(0, 63) * 16);
            beat.count = COUNT_W'($urandom_range(0, 48));
        end
        if (beat.cmd == CMD_INSERT && beat.count != '0) begin
            known_ranges.push_back({beat.count, beat.start});
            if (known_ranges.size() > KNOWN_DEPTH) void'(known_ranges.pop_front());
        end
    endtask

    task automatic random_phase(input int items);
        t_range_beat beat;
        int counted;
        counted = 0;
        while (counted < items) begin
            draw_item(beat);
            offer_item(beat);
            if (beat.cmd != CMD_SPARE) counted++;
            sender_pause();
        end
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        int waited;
        waited = 0;
        while (pending_results.size() > 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_results.size() > 0) begin
            flag_mismatch($sformatf("%0d expected results never arrived",
                                    pending_results.size()));
            pending_results.delete();
        end
    endtask

    task automatic write_limit(input logic [MAXE_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        tag_limit = value;
        limits_walked++;
    endtask

    initial begin
        foreach (tag_valid[k]) begin
            tag_valid[k] = 1'b0;
            tag_rank[k] = 0;
            tag_uses[k] = '0;
        end
        tag_used = 0;
        tag_limit = MAX_ENTRIES_RESET;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            offer_item(directed_plan[i]);
            sender_pause();
        end
        s_axis_tvalid <= 1'b0;
        wait_drained();

        // A stretch with no idling on either side, at the reset limit.
        tx_gaps = 1'b0;
        rx_stalls = 1'b0;
        random_phase(PHASE_ITEMS);
        wait_drained();
        rx_stalls = 1'b1;

        foreach (phase_limits[p]) begin
            wait_drained();
            write_limit(MAXE_W'(phase_limits[p]));
            if (p == 0) begin
                // The result side holds off while beats keep coming, so the block backs up.
                tx_gaps = 1'b0;
                hold_requests++;
            end else begin
                tx_gaps = 1'b1;
            end
            random_phase(PHASE_ITEMS);
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("run covered %0d input beats and %0d result beats: %0d lookup hits, %0d evictions",
                 beats_sent, results_seen, hits_predicted, evictions_predicted);
        $display("entry limit stepped through %0d settings from 0 to 31; %0d mismatches",
                 limits_walked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
